[src/uaf_pkg.sv]
// uaf_pkg: shared types and constants of the UDP amplification filter.
// Holds the table geometry, entry layout, cause codes and FSM states.
// No dependencies; every other file but uaf_ifs imports it.
`default_nettype none

package uaf_pkg;

    // Table geometry: direct-mapped, indexed by the low address bits
    localparam int TABLE_ENTRIES = 1024;
    localparam int TABLE_IDX_W   = $clog2(TABLE_ENTRIES);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [15:0] RATIO_RESET  = 16'd10;
    localparam logic [31:0] WINDOW_RESET = 32'd1000000000;

    // Header decode constants
    localparam logic [15:0] ETHER_IPV4     = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [13:0] MIN_IPV4_FRAME = 14'd34;
    localparam logic [13:0] ETH_UDP_BYTES  = 14'd22;
    localparam logic [3:0]  MIN_IHL        = 4'd5;

    // Reflector source ports
    localparam logic [15:0] CHARGEN_PORT   = 16'd19;
    localparam logic [15:0] DNS_PORT       = 16'd53;
    localparam logic [15:0] NTP_PORT       = 16'd123;
    localparam logic [15:0] SSDP_PORT      = 16'd1900;
    localparam logic [15:0] MEMCACHED_PORT = 16'd11211;

    // Saturation limits
    localparam logic [31:0] QUERY_MAX = '1;
    localparam logic [47:0] BYTES_MAX = '1;

    typedef enum logic [1:0] {
        CAUSE_NONE      = 2'd0,
        CAUSE_TRACKED   = 2'd1,
        CAUSE_BAD_IHL   = 2'd2,
        CAUSE_AMPLIFIED = 2'd3
    } cause_t;

    typedef enum logic [0:0] {
        REG_RATIO  = 1'b0,
        REG_WINDOW = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [31:0] queries;
        logic [47:0] bytes;
        logic [63:0] start;
    } entry_t;

    typedef struct packed {
        logic   tracked;
        logic   drop;
        cause_t cause;
    } cls_t;

    typedef struct packed {
        logic [15:0] ratio_threshold;
        logic [31:0] window_length_ns;
    } cfg_t;

endpackage

`default_nettype wire

[src/uaf_ifs.sv]
// uaf_ifs: valid/ready channels of the filter, header items in, verdict items out.
// Depends on nothing; field widths follow the parsed header layout.
`default_nettype none

interface uaf_header_if;
    logic        valid;
    logic        ready;
    logic [13:0] frame_bytes;
    logic [15:0] ether_type;
    logic [3:0]  header_words;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [15:0] udp_length;
    logic [63:0] now_ns;

    modport source (
        output valid, frame_bytes, ether_type, header_words, ip_protocol,
               source_address, source_port, udp_length, now_ns,
        input  ready
    );
    modport sink (
        input  valid, frame_bytes, ether_type, header_words, ip_protocol,
               source_address, source_port, udp_length, now_ns,
        output ready
    );
endinterface

interface uaf_verdict_if;
    logic       valid;
    logic       ready;
    logic       drop;
    logic [1:0] cause;

    modport source (output valid, drop, cause, input ready);
    modport sink (input valid, drop, cause, output ready);
endinterface

`default_nettype wire

[src/uaf_regs.sv]
// uaf_regs: APB register file holding ratio_threshold and window_length_ns.
// Depends on uaf_pkg.
`default_nettype none

module uaf_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [uaf_pkg::PADDR_W-1:0]  paddr,
    input  logic [uaf_pkg::PDATA_W-1:0]  pwdata,
    output logic [uaf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output uaf_pkg::cfg_t                cfg
);
    import uaf_pkg::*;

    logic [15:0] ratio_reg;
    logic [31:0] window_reg;
    logic        wr_en;
    reg_idx_t    idx;

    // Registers are word aligned; bit 2 selects the register
    assign idx    = reg_idx_t'(paddr[2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg  <= RATIO_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_RATIO:  ratio_reg  <= pwdata[15:0];
                REG_WINDOW: window_reg <= pwdata[31:0];
                default:    ratio_reg  <= ratio_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_RATIO:  prdata = {16'b0, ratio_reg};
            REG_WINDOW: prdata = window_reg;
            default:    prdata = '0;
        endcase
    end

    assign cfg.ratio_threshold  = ratio_reg;
    assign cfg.window_length_ns = window_reg;

endmodule

`default_nettype wire

[src/uaf_classify.sv]
// uaf_classify: header checks that mark items tracked in the table or drop bad IHL.
// Depends on uaf_pkg.
`default_nettype none

module uaf_classify (
    input  logic [13:0]   frame_bytes,
    input  logic [15:0]   ether_type,
    input  logic [3:0]    header_words,
    input  logic [7:0]    ip_protocol,
    input  logic [15:0]   source_port,
    output uaf_pkg::cls_t cls
);
    import uaf_pkg::*;

    logic        reflector;
    logic [13:0] min_udp_frame;

    // Match reflector source ports
    always_comb
    begin
        case (source_port) inside
            CHARGEN_PORT, DNS_PORT, NTP_PORT, SSDP_PORT, MEMCACHED_PORT:
                reflector = 1'b1;
            default:
                reflector = 1'b0;
        endcase
    end

    // Ethernet + IPv4 header + UDP header
    assign min_udp_frame = ETH_UDP_BYTES + {8'b0, header_words, 2'b00};

    // Walk the checks in priority order
    always_comb
    begin
        cls.tracked = 1'b0;
        cls.drop    = 1'b0;
        cls.cause   = CAUSE_NONE;
        if (ether_type != ETHER_IPV4 || frame_bytes < MIN_IPV4_FRAME)
        begin
            cls.cause = CAUSE_NONE;
        end
        else if (header_words < MIN_IHL)
        begin
            cls.drop  = 1'b1;
            cls.cause = CAUSE_BAD_IHL;
        end
        else if (ip_protocol == PROTO_UDP && frame_bytes >= min_udp_frame && reflector)
        begin
            cls.tracked = 1'b1;
            cls.cause   = CAUSE_TRACKED;
        end
    end

endmodule

`default_nettype wire

[src/uaf_table.sv]
// uaf_table: direct-mapped source table in one synchronous memory, with a
// clearing sweep after reset. Depends on uaf_pkg.
`default_nettype none

module uaf_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [uaf_pkg::TABLE_IDX_W-1:0] rd_idx,
    output uaf_pkg::entry_t                 rd_data,
    input  logic                            wr_en,
    input  logic [uaf_pkg::TABLE_IDX_W-1:0] wr_idx,
    input  uaf_pkg::entry_t                 wr_data,
    output logic                            clear_done
);
    import uaf_pkg::*;

    entry_t                 mem [TABLE_ENTRIES];
    entry_t                 rd_data_reg;
    logic [TABLE_IDX_W-1:0] clear_idx_reg;
    logic                   clear_done_reg;
    logic                   mem_we;
    logic [TABLE_IDX_W-1:0] mem_waddr;
    entry_t                 mem_wdata;

    // Sweep every slot invalid once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_idx_reg  <= '0;
            clear_done_reg <= 1'b0;
        end
        else if (!clear_done_reg)
        begin
            clear_idx_reg <= clear_idx_reg + 1'b1;
            if (clear_idx_reg == TABLE_IDX_W'(TABLE_ENTRIES - 1))
                clear_done_reg <= 1'b1;
        end
    end

    // Select the single write port
    always_comb
    begin
        if (!clear_done_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_idx;
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_idx];
    end

    assign rd_data    = rd_data_reg;
    assign clear_done = clear_done_reg;

endmodule

`default_nettype wire

[src/uaf_update.sv]
// uaf_update: next value of a table entry for a tracked item (install on miss
// or expired window, else saturating count and byte growth). Depends on uaf_pkg.
`default_nettype none

module uaf_update (
    input  uaf_pkg::entry_t old_entry,
    input  logic [31:0]     address,
    input  logic [15:0]     udp_length,
    input  logic [63:0]     now_ns,
    input  logic [31:0]     window_length_ns,
    output uaf_pkg::entry_t upd_entry,
    output logic            restart
);
    import uaf_pkg::*;

    logic        hit;
    logic [63:0] elapsed;
    logic        expired;
    logic [31:0] queries_inc;
    logic [48:0] bytes_sum;
    logic [47:0] bytes_sat;

    // Tag match and window age (timestamps wrap)
    assign hit     = old_entry.valid && (old_entry.address == address);
    assign elapsed = now_ns - old_entry.start;
    assign expired = elapsed >= {32'b0, window_length_ns};
    assign restart = !hit || expired;

    // Saturating growth
    assign queries_inc = (old_entry.queries == QUERY_MAX) ? QUERY_MAX
                                                          : old_entry.queries + 32'd1;
    assign bytes_sum   = {1'b0, old_entry.bytes} + {33'b0, udp_length};
    assign bytes_sat   = bytes_sum[48] ? BYTES_MAX : bytes_sum[47:0];

    always_comb
    begin
        upd_entry.valid   = 1'b1;
        upd_entry.address = address;
        if (restart)
        begin
            upd_entry.queries = 32'd1;
            upd_entry.bytes   = {32'b0, udp_length};
            upd_entry.start   = now_ns;
        end
        else
        begin
            upd_entry.queries = queries_inc;
            upd_entry.bytes   = bytes_sat;
            upd_entry.start   = old_entry.start;
        end
    end

endmodule

`default_nettype wire

[src/udp_amplification_filter_top.sv]
// Top level of the UDP amplification filter: sequencer, table read-modify-write
// and verdict stage. Depends on uaf_pkg, uaf_ifs and the uaf_* submodules.
//
// One parsed header enters per item and one verdict item leaves. After reset the
// block sweeps its 1024-entry source table invalid, one slot per cycle, and takes
// no item until the sweep is done and the sequencer has left its clear state
// (register writes are taken throughout). Each item then takes these steps: the
// state that accepts it issues the table read, the lookup state updates the entry
// and writes it back, and the decide state multiplies the query count by 64 times
// the threshold plus one to form the verdict and loads it into the output
// register. The decide state accepts the next item when the output register is
// free, so a new item is taken before the last one is through. The verdict sits
// in an output register, so a stalled sink holds only the decide stage while one
// more item is taken.
`default_nettype none

module udp_amplification_filter_top (
    input  logic                         clk,
    input  logic                         rst_n,
    uaf_header_if.sink                   header,
    uaf_verdict_if.source                verdict,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [uaf_pkg::PADDR_W-1:0]  paddr,
    input  logic [uaf_pkg::PDATA_W-1:0]  pwdata,
    output logic [uaf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import uaf_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    cfg_t        cfg;
    cls_t        cls_in;
    logic        clear_done;
    logic        accept;
    logic        out_free;
    logic        in_ready;
    logic        load_out;
    logic        tbl_we;

    // Item registers
    cls_t        cls_reg;
    logic [31:0] addr_reg;
    logic [15:0] len_reg;
    logic [63:0] now_reg;

    // Update results
    entry_t      old_entry;
    entry_t      upd_entry;
    logic        restart;
    logic [31:0] queries_reg;
    logic [47:0] bytes_reg;
    logic        restart_reg;

    // Verdict
    logic [22:0] mult_k;
    logic [54:0] limit;
    logic        amplified;
    logic        drop_d;
    cause_t      cause_d;
    logic        out_valid_reg;
    logic        out_drop_reg;
    cause_t      out_cause_reg;

    uaf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uaf_classify u_classify (
        .frame_bytes  (header.frame_bytes),
        .ether_type   (header.ether_type),
        .header_words (header.header_words),
        .ip_protocol  (header.ip_protocol),
        .source_port  (header.source_port),
        .cls          (cls_in)
    );

    uaf_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_idx     (header.source_address[TABLE_IDX_W-1:0]),
        .rd_data    (old_entry),
        .wr_en      (tbl_we),
        .wr_idx     (addr_reg[TABLE_IDX_W-1:0]),
        .wr_data    (upd_entry),
        .clear_done (clear_done)
    );

    uaf_update u_update (
        .old_entry        (old_entry),
        .address          (addr_reg),
        .udp_length       (len_reg),
        .now_ns           (now_reg),
        .window_length_ns (cfg.window_length_ns),
        .upd_entry        (upd_entry),
        .restart          (restart)
    );

    assign out_free = !out_valid_reg || verdict.ready;
    assign accept   = header.valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clear_done)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                    state_next = ST_LOOKUP;
            ST_LOOKUP:
                state_next = ST_DECIDE;
            ST_DECIDE:
                if (out_free)
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        tbl_we   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  in_ready = 1'b0;
            ST_IDLE:   in_ready = 1'b1;
            ST_LOOKUP: tbl_we   = cls_reg.tracked;
            ST_DECIDE:
            begin
                in_ready = out_free;
                load_out = out_free;
            end
            default:   in_ready = 1'b0;
        endcase
    end

    assign header.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Capture the item on acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cls_reg  <= cls_in;
            addr_reg <= header.source_address;
            len_reg  <= header.udp_length;
            now_reg  <= header.now_ns;
        end
    end

    // Hold the updated counts for the decide stage
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOKUP)
        begin
            queries_reg <= upd_entry.queries;
            bytes_reg   <= upd_entry.bytes;
            restart_reg <= restart;
        end
    end

    // floor(bytes/queries) > 64*T  <=>  bytes >= queries * (64*T + 1)
    assign mult_k    = {1'b0, cfg.ratio_threshold, 6'b0} + 23'd1;
    assign limit     = 55'(queries_reg) * 55'(mult_k);
    assign amplified = {7'b0, bytes_reg} >= limit;

    // Pick the verdict
    always_comb
    begin
        if (!cls_reg.tracked)
        begin
            drop_d  = cls_reg.drop;
            cause_d = cls_reg.cause;
        end
        else if (restart_reg || !amplified)
        begin
            drop_d  = 1'b0;
            cause_d = CAUSE_TRACKED;
        end
        else
        begin
            drop_d  = 1'b1;
            cause_d = CAUSE_AMPLIFIED;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (verdict.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_drop_reg  <= drop_d;
            out_cause_reg <= cause_d;
        end
    end

    assign verdict.valid = out_valid_reg;
    assign verdict.drop  = out_drop_reg;
    assign verdict.cause = out_cause_reg;

endmodule

`default_nettype wire

[src/uaf_checker.sv]
// uaf_checker: port-level assertions for the filter top, attached by bind.
// Depends on uaf_pkg and udp_amplification_filter_top.
`default_nettype none

module uaf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_drop,
    input logic [1:0] out_cause
);
    import uaf_pkg::*;

    // Drop flag agrees with the cause code
    a_drop_matches_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_drop == (out_cause == CAUSE_BAD_IHL ||
                                    out_cause == CAUSE_AMPLIFIED)))
        else $error("verdict drop flag disagrees with cause");

    // Table read-modify-write occupies the cycle after acceptance
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted during table update");

    // Stalled verdict holds
    a_verdict_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_drop) &&
                                       $stable(out_cause)))
        else $error("stalled verdict changed");

    // No verdict is loaded while the table update of a new item runs
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 !$rose(out_valid))
        else $error("verdict loaded during table update");

endmodule

bind udp_amplification_filter_top uaf_checker u_uaf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (header.valid),
    .in_ready  (header.ready),
    .out_valid (verdict.valid),
    .out_ready (verdict.ready),
    .out_drop  (verdict.drop),
    .out_cause (verdict.cause)
);

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for udp_amplification_filter_top: directed header table, then random
// traffic, with an in-bench verdict predictor and per-source table mirror.
// Depends on uaf_pkg, uaf_ifs and the filter RTL.
`default_nettype none

module testbench;
    import uaf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 160;
    localparam int QUIET_ITEMS    = 100;
    localparam int PHASES         = 5;

    typedef struct packed {
        logic [13:0] frame_bytes;
        logic [15:0] ether_type;
        logic [3:0]  header_words;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [15:0] udp_length;
        logic [63:0] now_ns;
    } header_t;

    typedef struct packed {
        logic   drop;
        cause_t cause;
    } verdict_t;

    typedef struct {
        header_t  hdr;
        bit       typed;
        verdict_t vrd;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    uaf_header_if  hdr_ch();
    uaf_verdict_if vrd_ch();

    udp_amplification_filter_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .header  (hdr_ch),
        .verdict (vrd_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the source table and registers
    logic        src_valid   [TABLE_ENTRIES];
    logic [31:0] src_address [TABLE_ENTRIES];
    logic [31:0] src_queries [TABLE_ENTRIES];
    logic [47:0] src_bytes   [TABLE_ENTRIES];
    logic [63:0] src_start   [TABLE_ENTRIES];
    logic [15:0] ratio_mirror;
    logic [31:0] window_mirror;

    verdict_t    pending_verdicts[$];
    stim_row_t   directed_rows[$];
    int          errors;
    bit          quiet;
    bit          hold_req;
    logic [63:0] now_cursor;
    logic [31:0] now_step;
    logic [31:0] addr_pool[8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the verdict of one accepted header and update the table mirror
    function automatic verdict_t filter_verdict(header_t h);
        logic [TABLE_IDX_W-1:0] idx;
        logic [63:0]            age;
        logic [47:0]            avg;
        verdict_t               v;
        v.drop  = 1'b0;
        v.cause = CAUSE_NONE;
        if (h.frame_bytes < 14 || h.ether_type != ETHER_IPV4 || h.frame_bytes < 34)
            return v;
        if (h.header_words < 5)
        begin
            v.drop  = 1'b1;
            v.cause = CAUSE_BAD_IHL;
            return v;
        end
        if (h.ip_protocol != PROTO_UDP)
            return v;
        if (32'(h.frame_bytes) < 22 + 4 * 32'(h.header_words))
            return v;
        if (!(h.source_port inside {DNS_PORT, NTP_PORT, SSDP_PORT, MEMCACHED_PORT,
                                    CHARGEN_PORT}))
            return v;

        idx     = h.source_address[TABLE_IDX_W-1:0];
        age     = h.now_ns - src_start[idx];
        v.cause = CAUSE_TRACKED;
        // miss or expired window: restart the entry and pass
        if (!src_valid[idx] || src_address[idx] != h.source_address ||
            age >= 64'(window_mirror))
        begin
            src_valid[idx]   = 1'b1;
            src_address[idx] = h.source_address;
            src_queries[idx] = 32'd1;
            src_bytes[idx]   = 48'(h.udp_length);
            src_start[idx]   = h.now_ns;
            return v;
        end

        // grow the window totals, saturating
        if (src_queries[idx] != QUERY_MAX)
            src_queries[idx] = src_queries[idx] + 32'd1;
        if (src_bytes[idx] > BYTES_MAX - 48'(h.udp_length))
            src_bytes[idx] = BYTES_MAX;
        else
            src_bytes[idx] = src_bytes[idx] + 48'(h.udp_length);

        avg = src_bytes[idx] / 48'(src_queries[idx]);
        if (64'(avg) > 64'(ratio_mirror) * 64)
        begin
            v.drop  = 1'b1;
            v.cause = CAUSE_AMPLIFIED;
        end
        return v;
    endfunction

    // Build one random header: mostly well-formed reflector traffic, some broken, some noise
    function automatic header_t random_header();
        header_t     h;
        int          pick;
        logic [15:0] reflectors[5];
        reflectors = '{DNS_PORT, NTP_PORT, SSDP_PORT, MEMCACHED_PORT, CHARGEN_PORT};
        pick       = $urandom_range(0, 99);

        // advance the timestamp, with an occasional jump anywhere
        if ($urandom_range(0, 19) == 0)
            now_cursor = {$urandom, $urandom};
        else
            now_cursor = now_cursor + 64'($urandom_range(0, now_step));

        h.header_words   = 4'($urandom_range(5, 15));
        h.frame_bytes    = 14'($urandom_range(22 + 4 * h.header_words,
                                              ($urandom_range(0, 9) == 0) ? 16383 : 1514));
        h.ether_type     = ETHER_IPV4;
        h.ip_protocol    = PROTO_UDP;
        h.source_address = ($urandom_range(0, 9) == 0) ? $urandom
                                                        : addr_pool[$urandom_range(0, 7)];
        h.source_port    = reflectors[$urandom_range(0, 4)];
        case ($urandom_range(0, 4))
            0, 1:    h.udp_length = 16'($urandom_range(0, 700));
            2:       h.udp_length = 16'($urandom_range(0, 100));
            default: h.udp_length = 16'($urandom);
        endcase
        h.now_ns = now_cursor;

        if (pick >= 90)
        begin
            h.frame_bytes    = 14'($urandom);
            h.ether_type     = ($urandom_range(0, 1) == 0) ? ETHER_IPV4 : 16'($urandom);
            h.header_words   = 4'($urandom);
            h.ip_protocol    = 8'($urandom);
            h.source_address = $urandom;
            h.source_port    = 16'($urandom);
            h.udp_length     = 16'($urandom);
            h.now_ns         = {$urandom, $urandom};
        end
        else if (pick >= 70)
        begin
            // break one field of a well-formed header
            case ($urandom_range(0, 4))
                0:       h.ether_type   = 16'($urandom);
                1:       h.header_words = 4'($urandom_range(0, 4));
                2:       h.ip_protocol  = 8'($urandom);
                3:       h.frame_bytes  = 14'($urandom_range(0, 21 + 4 * h.header_words));
                default: h.source_port  = 16'($urandom);
            endcase
        end
        return h;
    endfunction

    task automatic add_row(logic [13:0] frame, logic [15:0] etype, logic [3:0] words,
                           logic [7:0] proto, logic [31:0] addr, logic [15:0] port,
                           logic [15:0] len, logic [63:0] now, bit typed,
                           logic drop, cause_t cause);
        stim_row_t row;
        row.hdr       = '{frame, etype, words, proto, addr, port, len, now};
        row.typed     = typed;
        row.vrd.drop  = drop;
        row.vrd.cause = cause;
        directed_rows.push_back(row);
    endtask

    // Offer one header item, hold it until taken, then queue its verdict
    task automatic offer_header(header_t h, bit typed, verdict_t typed_v);
        verdict_t predicted;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            hdr_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        hdr_ch.valid          <= 1'b1;
        hdr_ch.frame_bytes    <= h.frame_bytes;
        hdr_ch.ether_type     <= h.ether_type;
        hdr_ch.header_words   <= h.header_words;
        hdr_ch.ip_protocol    <= h.ip_protocol;
        hdr_ch.source_address <= h.source_address;
        hdr_ch.source_port    <= h.source_port;
        hdr_ch.udp_length     <= h.udp_length;
        hdr_ch.now_ns         <= h.now_ns;
        @(posedge clk);
        while (!hdr_ch.ready)
            @(posedge clk);
        predicted = filter_verdict(h);
        pending_verdicts.push_back(typed ? typed_v : predicted);
    endtask

    // Write one register, read it back, and update the mirror
    task automatic program_register(reg_idx_t r, logic [31:0] value);
        logic [31:0] readback_exp;
        readback_exp = (r == REG_RATIO) ? {16'b0, value[15:0]} : value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== readback_exp)
        begin
            $display("%0t: register %0d readback, expected %0h, actual %0h",
                     $time, r, readback_exp, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (r == REG_RATIO)
            ratio_mirror = value[15:0];
        else
            window_mirror = value;
    endtask

    // Hold until every queued verdict has arrived
    task automatic drain_verdicts();
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        logic [15:0] ratio_pick;
        logic [31:0] window_pick;
        errors   = 0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            src_valid[i]   = 1'b0;
            src_address[i] = '0;
            src_queries[i] = '0;
            src_bytes[i]   = '0;
            src_start[i]   = '0;
        end
        ratio_mirror  = RATIO_RESET;
        window_mirror = WINDOW_RESET;
        now_cursor    = '0;

        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        hdr_ch.valid          <= 1'b0;
        hdr_ch.frame_bytes    <= '0;
        hdr_ch.ether_type     <= '0;
        hdr_ch.header_words   <= '0;
        hdr_ch.ip_protocol    <= '0;
        hdr_ch.source_address <= '0;
        hdr_ch.source_port    <= '0;
        hdr_ch.udp_length     <= '0;
        hdr_ch.now_ns         <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        program_register(REG_RATIO, 32'(RATIO_RESET));
        program_register(REG_WINDOW, WINDOW_RESET);

        // short frames and non-IPv4 pass uninspected
        add_row(14'd0, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd100, 64'd0,
                1, 1'b0, CAUSE_NONE);
        add_row(14'd13, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd100, 64'd0,
                1, 1'b0, CAUSE_NONE);
        add_row(14'd33, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd100, 64'd0,
                1, 1'b0, CAUSE_NONE);
        add_row(14'd100, 16'h86DD, 4'd5, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd100, 64'd0,
                1, 1'b0, CAUSE_NONE);
        add_row(14'd16383, 16'hFFFF, 4'd15, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, '1,
                1, 1'b0, CAUSE_NONE);
        // bad header length drops, checked ahead of the protocol
        add_row(14'd34, ETHER_IPV4, 4'd0, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd100, 64'd0,
                1, 1'b1, CAUSE_BAD_IHL);
        add_row(14'd100, ETHER_IPV4, 4'd4, 8'd6, 32'h0A000001, DNS_PORT, 16'd100, 64'd0,
                1, 1'b1, CAUSE_BAD_IHL);
        // not UDP, truncated UDP, non-reflector ports
        add_row(14'd100, ETHER_IPV4, 4'd5, 8'd6, 32'h0A000001, DNS_PORT, 16'd100, 64'd0,
                1, 1'b0, CAUSE_NONE);
        add_row(14'd81, ETHER_IPV4, 4'd15, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd100, 64'd0,
                1, 1'b0, CAUSE_NONE);
        add_row(14'd41, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd100, 64'd0,
                1, 1'b0, CAUSE_NONE);
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, 16'd0, 16'd100, 64'd0,
                1, 1'b0, CAUSE_NONE);
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, 16'd54, 16'd100, 64'd0,
                1, 1'b0, CAUSE_NONE);
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, 16'hFFFF, 16'd100, 64'd0,
                1, 1'b0, CAUSE_NONE);
        // first sight of a source installs an entry
        add_row(14'd16383, ETHER_IPV4, 4'd15, PROTO_UDP, 32'hFFFFFFFF, CHARGEN_PORT,
                16'hFFFF, '1, 1, 1'b0, CAUSE_TRACKED);
        add_row(14'd42, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h00000000, NTP_PORT, 16'd0, 64'd0,
                1, 1'b0, CAUSE_TRACKED);
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, SSDP_PORT, 16'd100,
                64'd1000, 1, 1'b0, CAUSE_TRACKED);
        // repeats from one source grow its totals
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, MEMCACHED_PORT, 16'd2000,
                64'd2000, 0, 1'b0, CAUSE_NONE);
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd0,
                64'd3000, 0, 1'b0, CAUSE_NONE);
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd0,
                64'd3000, 0, 1'b0, CAUSE_NONE);
        // a colliding source evicts the entry, then the first one comes back
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000401, DNS_PORT, 16'd300,
                64'd2500, 1, 1'b0, CAUSE_TRACKED);
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd300,
                64'd2500, 1, 1'b0, CAUSE_TRACKED);
        // last nanosecond inside the window, then the first one outside it
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd700,
                64'd1000002499, 0, 1'b0, CAUSE_NONE);
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'h0A000001, DNS_PORT, 16'd700,
                64'd1000002500, 0, 1'b0, CAUSE_NONE);
        // timestamp wraps past zero and the window stays open
        add_row(14'd100, ETHER_IPV4, 4'd5, PROTO_UDP, 32'hFFFFFFFF, DNS_PORT, 16'd0,
                64'd5, 0, 1'b0, CAUSE_NONE);

        foreach (directed_rows[i])
            offer_header(directed_rows[i].hdr, directed_rows[i].typed, directed_rows[i].vrd);
        hdr_ch.valid <= 1'b0;

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    ratio_pick  = '0;
                    window_pick = '1;
                end
                1:
                begin
                    ratio_pick  = '1;
                    window_pick = 32'd1;
                end
                2:
                begin
                    ratio_pick  = 16'd1;
                    window_pick = '0;
                end
                3:
                begin
                    ratio_pick  = 16'($urandom_range(0, 30));
                    window_pick = $urandom_range(10, 100000);
                end
                default:
                begin
                    ratio_pick  = 16'($urandom);
                    window_pick = $urandom;
                end
            endcase
            drain_verdicts();
            program_register(REG_RATIO, 32'(ratio_pick));
            program_register(REG_WINDOW, window_pick);
            now_step = (window_pick == 0) ? 32'd2 : window_pick / 3 + 32'd1;

            // keep two pool addresses on one slot so they evict each other
            foreach (addr_pool[i])
                addr_pool[i] = $urandom;
            addr_pool[1] = {22'($urandom), addr_pool[0][TABLE_IDX_W-1:0]};

            if (p == 1)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == PHASES - 1 && i >= PHASE_ITEMS - QUIET_ITEMS)
                    quiet = 1'b1;
                offer_header(random_header(), 0, '0);
            end
            hdr_ch.valid <= 1'b0;
        end

        drain_verdicts();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Verdict receiver: random short stalls, and one long hold on request
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        vrd_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                vrd_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                vrd_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                vrd_ch.ready <= 1'b0;
            end
            else
                vrd_ch.ready <= 1'b1;
        end
    end

    // Compare each verdict item with the oldest queued one
    always @(posedge clk)
    begin
        verdict_t want;
        if (vrd_ch.valid && vrd_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: verdict with none expected, actual drop %0b cause %0d",
                         $time, vrd_ch.drop, vrd_ch.cause);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (vrd_ch.drop !== want.drop)
                begin
                    $display("%0t: drop mismatch, expected %0b, actual %0b",
                             $time, want.drop, vrd_ch.drop);
                    errors++;
                end
                if (vrd_ch.cause !== want.cause)
                begin
                    $display("%0t: cause mismatch, expected %0d, actual %0d",
                             $time, want.cause, vrd_ch.cause);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((hdr_ch.valid && hdr_ch.ready) || (vrd_ch.valid && vrd_ch.ready) ||
                (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

[udp_amplification_filter_top.f]
src/uaf_pkg.sv
src/uaf_ifs.sv
src/uaf_regs.sv
src/uaf_classify.sv
src/uaf_table.sv
src/uaf_update.sv
src/udp_amplification_filter_top.sv
src/uaf_checker.sv
bench/testbench.sv
